// ===== design/rtp_header_parser_unit_assert.svh =====
// Assertion macros shared by the RTP header parser modules.
`ifndef RTP_HEADER_PARSER_UNIT_ASSERT_SVH
`define RTP_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RHP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtp header parser: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtp header parser: next-cycle check failed");

`endif

// ===== design/rhp_pkg.sv =====
// Shared constants, codes and event types of the RTP header parser.
package rhp_pkg;

  localparam int COUNT_BITS = 20;
  localparam int CMP_BITS   = COUNT_BITS + 2;
  localparam int HDR_BYTES  = 12;
  localparam int HL_BITS    = 19;

  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_CSRC_BEYOND = 3'd3,
    ST_EXT_BEYOND  = 3'd4,
    ST_HDR_BEYOND  = 3'd5
  } status_t;

  localparam logic KIND_CSRC    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    status_t             status;
    logic                padding_flag;
    logic                extension_flag;
    logic [3:0]          contrib_count;
    logic                marker_flag;
    logic [6:0]          media_type;
    logic [15:0]         sequence_number;
    logic [31:0]         media_stamp;
    logic [31:0]         source_id;
    logic [HL_BITS-1:0]  header_length;
  } verdict_t;

  typedef struct packed {
    logic        has_csrc;
    logic [31:0] csrc_value;
    logic        has_verdict;
    verdict_t    verdict;
  } evt_t;

  typedef struct packed {
    logic        kind;
    verdict_t    verdict;
    logic [31:0] csrc_value;
  } beat_t;

endpackage

// ===== design/rtp_header_parser_unit.sv =====
// Top level of the RTP header parser: front end, event queue and result stage.
//
// The parser takes one packet byte per cycle (push/full) with last_byte on
// the final byte, and returns results through a queue-style port
// (empty/pop). A front end captures the fixed 12-byte header, the CSRC words
// and the extension length, and turns each byte into at most one event
// holding a completed CSRC word, a packet verdict, or both. Events wait in a
// four-entry queue; the result stage emits them from an output register, one
// beat per cycle, so a byte that yields both a CSRC word and a verdict costs
// two result beats. Input throughput is one byte per cycle while results are
// popped every cycle; the first result of a byte passes through the event
// queue and then the output register. full rises only when the event queue
// holds four events and the output register is stalled by pop held low.
// Verdict status codes follow the check order: short packet, bad version,
// CSRC list beyond packet, extension header beyond packet, full header beyond
// packet, else ok. The byte count saturates at 2^20-1.
module rtp_header_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // Result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic        out_padding_flag,
  output logic        out_extension_flag,
  output logic [3:0]  out_contrib_count,
  output logic        out_marker_flag,
  output logic [6:0]  out_media_type,
  output logic [15:0] out_sequence_number,
  output logic [31:0] out_media_stamp,
  output logic [31:0] out_source_id,
  output logic [18:0] out_header_length,
  output logic [31:0] out_csrc_value
);
  import rhp_pkg::*;

  logic  acc;
  logic  evt_valid;
  evt_t  evt;
  evt_t  q_head;
  logic  q_empty, q_full, q_rd;
  logic  out_valid;
  beat_t beat;

  // Accept a byte whenever push is high and the event queue has room.
  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  rhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  rhp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (evt_valid),
    .wr_data (evt),
    .rd      (q_rd),
    .rd_data (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  rhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_rd      (q_rd),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_beat  (beat)
  );

  // Drive the result ports straight from the output register.
  assign out_empty           = !out_valid;
  assign out_kind            = beat.kind;
  assign out_status          = beat.verdict.status;
  assign out_padding_flag    = beat.verdict.padding_flag;
  assign out_extension_flag  = beat.verdict.extension_flag;
  assign out_contrib_count   = beat.verdict.contrib_count;
  assign out_marker_flag     = beat.verdict.marker_flag;
  assign out_media_type      = beat.verdict.media_type;
  assign out_sequence_number = beat.verdict.sequence_number;
  assign out_media_stamp     = beat.verdict.media_stamp;
  assign out_source_id       = beat.verdict.source_id;
  assign out_header_length   = beat.verdict.header_length;
  assign out_csrc_value      = beat.csrc_value;

endmodule

// ===== design/rhp_front.sv =====
// Front end: captures header bytes and classifies each byte into result events.
module rhp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          evt_valid,
  output rhp_pkg::evt_t evt
);
  import rhp_pkg::*;

  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [7:0]  fb_r, fb_nxt, sb_r, sb_nxt;
  logic [15:0] seq_r, seq_nxt, ext_r, ext_nxt;
  logic [31:0] ts_r, ts_nxt, src_r, src_nxt, csrc_r, csrc_nxt;

  logic [6:0]  base, p7;
  logic        ver_ok, in_small, in_csrc, in_ext, has_csrc;
  logic [CMP_BITS-1:0] len, base_c, hl_ext, hl;
  verdict_t    verd;

  always_comb begin
    fb_nxt  = fb_r;
    sb_nxt  = sb_r;
    seq_nxt = seq_r;
    ts_nxt  = ts_r;
    src_nxt = src_r;
    if (cnt_r == '0) begin
      fb_nxt = data_byte;
    end else if (cnt_r == COUNT_BITS'(1)) begin
      sb_nxt = data_byte;
    end else if (cnt_r < COUNT_BITS'(4)) begin
      seq_nxt = {seq_r[7:0], data_byte};
    end else if (cnt_r < COUNT_BITS'(8)) begin
      ts_nxt = {ts_r[23:0], data_byte};
    end else if (cnt_r < COUNT_BITS'(HDR_BYTES)) begin
      src_nxt = {src_r[23:0], data_byte};
    end

    base     = {1'b0, fb_nxt[3:0], 2'b00} + 7'(HDR_BYTES);
    ver_ok   = (fb_nxt[7:6] == 2'b10);
    in_small = (cnt_r[COUNT_BITS-1:7] == '0);
    p7       = cnt_r[6:0];

    // Contributing-source list occupies bytes 12 .. base-1.
    in_csrc  = in_small && (p7 >= 7'(HDR_BYTES)) && (p7 < base);
    csrc_nxt = in_csrc ? {csrc_r[23:0], data_byte} : csrc_r;
    has_csrc = in_csrc && (cnt_r[1:0] == 2'b11) && ver_ok;

    // Extension length sits two and three bytes past the list.
    in_ext  = fb_nxt[4] && in_small && (p7 >= 7'(HDR_BYTES)) &&
              ((p7 == base + 7'd2) || (p7 == base + 7'd3));
    ext_nxt = in_ext ? {ext_r[7:0], data_byte} : ext_r;

    cnt_nxt = (cnt_r != '1) ? cnt_r + COUNT_BITS'(1) : cnt_r;

    len    = CMP_BITS'(cnt_nxt);
    base_c = CMP_BITS'(base);
    hl_ext = base_c + CMP_BITS'(4) + CMP_BITS'({ext_nxt, 2'b00});
    hl     = fb_nxt[4] ? hl_ext : base_c;

    verd = '0;
    if (len < CMP_BITS'(HDR_BYTES)) begin
      verd.status = ST_SHORT;
    end else begin
      verd.padding_flag    = fb_nxt[5];
      verd.extension_flag  = fb_nxt[4];
      verd.contrib_count   = fb_nxt[3:0];
      verd.marker_flag     = sb_nxt[7];
      verd.media_type      = sb_nxt[6:0];
      verd.sequence_number = seq_nxt;
      verd.media_stamp     = ts_nxt;
      verd.source_id       = src_nxt;
      if (!ver_ok) begin
        verd.status = ST_BAD_VERSION;
      end else if (base_c > len) begin
        verd.status = ST_CSRC_BEYOND;
      end else if (fb_nxt[4] && (base_c + CMP_BITS'(4) > len)) begin
        verd.status = ST_EXT_BEYOND;
      end else begin
        verd.status        = (hl > len) ? ST_HDR_BEYOND : ST_OK;
        verd.header_length = hl[HL_BITS-1:0];
      end
    end

    evt.has_csrc    = has_csrc;
    evt.csrc_value  = csrc_nxt;
    evt.has_verdict = last_byte;
    evt.verdict     = verd;
    evt_valid       = acc && (has_csrc || last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last_byte)) begin
      cnt_r  <= '0;
      fb_r   <= '0;
      sb_r   <= '0;
      seq_r  <= '0;
      ts_r   <= '0;
      src_r  <= '0;
      csrc_r <= '0;
      ext_r  <= '0;
    end else if (acc) begin
      cnt_r  <= cnt_nxt;
      fb_r   <= fb_nxt;
      sb_r   <= sb_nxt;
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      src_r  <= src_nxt;
      csrc_r <= csrc_nxt;
      ext_r  <= ext_nxt;
    end
  end

endmodule

// ===== design/rhp_queue.sv =====
// Short event queue between the front end and the result stage.
`include "rtp_header_parser_unit_assert.svh"
module rhp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  rhp_pkg::evt_t wr_data,
  input  logic          rd,
  output rhp_pkg::evt_t rd_data,
  output logic          empty,
  output logic          full
);
  import rhp_pkg::*;

  evt_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wptr_r, rptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic                 do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCNT_BITS'(QDEPTH));
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + QPTR_BITS'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + QPTR_BITS'(1);
      end
      cnt_r <= cnt_r + QCNT_BITS'(do_wr) - QCNT_BITS'(do_rd);
    end
  end

  `RHP_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= QCNT_BITS'(QDEPTH))
  `RHP_ASSERT_NEXT(a_cnt_grow, clk, rst_n, do_wr && !do_rd, cnt_r == $past(cnt_r) + QCNT_BITS'(1))

endmodule

// ===== design/rhp_back.sv =====
// Result stage: splits queued events into beats and holds the output register.
`include "rtp_header_parser_unit_assert.svh"
module rhp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  rhp_pkg::evt_t  q_head,
  output logic           q_rd,
  input  logic           out_pop,
  output logic           out_valid,
  output rhp_pkg::beat_t out_beat
);
  import rhp_pkg::*;

  logic  valid_r, valid_nxt;
  logic  sent_r, sent_nxt;
  beat_t beat_r, beat_nxt;
  logic  load;

  always_comb begin
    load      = !q_empty && (!valid_r || out_pop);
    q_rd      = 1'b0;
    sent_nxt  = sent_r;
    beat_nxt  = beat_r;
    valid_nxt = valid_r && !out_pop;
    if (load) begin
      valid_nxt = 1'b1;
      if (q_head.has_csrc && !sent_r) begin
        beat_nxt.kind       = KIND_CSRC;
        beat_nxt.verdict    = '0;
        beat_nxt.csrc_value = q_head.csrc_value;
        sent_nxt            = q_head.has_verdict;
        q_rd                = !q_head.has_verdict;
      end else begin
        beat_nxt.kind       = KIND_VERDICT;
        beat_nxt.verdict    = q_head.verdict;
        beat_nxt.csrc_value = '0;
        sent_nxt            = 1'b0;
        q_rd                = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sent_r  <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  `RHP_ASSERT_IMPL(a_sent_head, clk, rst_n, sent_r, !q_empty && q_head.has_csrc && q_head.has_verdict)
  `RHP_ASSERT_NEXT(a_split_csrc_first, clk, rst_n, load && !sent_r && q_head.has_csrc && q_head.has_verdict, sent_r && valid_r && (beat_r.kind == KIND_CSRC))

endmodule

// ===== sim/rtp_header_parser_unit_test.sv =====
// Self-checking testbench for the RTP header parser: packet stimulus, prediction and result checks.
`timescale 1ns / 1ps

module rtp_header_parser_unit_test;
  import rhp_pkg::*;

  // Header byte patterns for the packet builder
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS  = 1;
  localparam int FILL_ONES   = 2;

  localparam logic [1:0] RTP_VERSION = 2'd2;
  localparam int RANDOM_BYTES = 140;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_kind;
  logic [2:0]  out_status;
  logic        out_padding_flag;
  logic        out_extension_flag;
  logic [3:0]  out_contrib_count;
  logic        out_marker_flag;
  logic [6:0]  out_media_type;
  logic [15:0] out_sequence_number;
  logic [31:0] out_media_stamp;
  logic [31:0] out_source_id;
  logic [18:0] out_header_length;
  logic [31:0] out_csrc_value;

  rtp_header_parser_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_status         (out_status),
    .out_padding_flag   (out_padding_flag),
    .out_extension_flag (out_extension_flag),
    .out_contrib_count  (out_contrib_count),
    .out_marker_flag    (out_marker_flag),
    .out_media_type     (out_media_type),
    .out_sequence_number(out_sequence_number),
    .out_media_stamp    (out_media_stamp),
    .out_source_id      (out_source_id),
    .out_header_length  (out_header_length),
    .out_csrc_value     (out_csrc_value)
  );

  always #4 clk = ~clk;

  // Shadow copy of the parser state, advanced once per accepted byte
  logic [COUNT_BITS-1:0] pkt_count = '0;
  logic [7:0]            hdr_byte0 = '0;
  logic [7:0]            hdr_byte1 = '0;
  logic [15:0]           seq_acc = '0;
  logic [31:0]           ts_acc = '0;
  logic [31:0]           ssrc_acc = '0;
  logic [31:0]           csrc_acc = '0;
  logic [15:0]           ext_len_acc = '0;

  beat_t       expected_rtp_beats[$];
  logic [7:0]  pkt_bytes[$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int csrc_beats_seen = 0;
  int verdicts_seen = 0;
  int full_stall_cycles = 0;
  int pop_wait = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit rx_held = 1'b0;

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the shadow parser by one byte and queue the beats it yields.
  task automatic predict_rtp_beats(input logic [7:0] d, input logic last);
    logic [31:0] p;
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] hl;
    logic        ver_ok;
    logic        has_ext;
    beat_t       want;
    p = {{(32-COUNT_BITS){1'b0}}, pkt_count};
    // Fixed header: capture each field at its byte position, big-endian
    if (p == 0) hdr_byte0 = d;
    else if (p == 1) hdr_byte1 = d;
    else if (p < 4) seq_acc = {seq_acc[7:0], d};
    else if (p < 8) ts_acc = {ts_acc[23:0], d};
    else if (p < HDR_BYTES) ssrc_acc = {ssrc_acc[23:0], d};

    base    = HDR_BYTES + {26'd0, hdr_byte0[3:0], 2'b00};
    ver_ok  = hdr_byte0[7:6] == RTP_VERSION;
    has_ext = hdr_byte0[4];

    // CSRC list: emit a word on its fourth byte, but only for version 2
    if (p >= HDR_BYTES && p < base) begin
      csrc_acc = {csrc_acc[23:0], d};
      if (p[1:0] == 2'd3 && ver_ok) begin
        want = '0;
        want.kind = KIND_CSRC;
        want.csrc_value = csrc_acc;
        expected_rtp_beats.push_back(want);
      end
    end

    // Extension length sits two bytes into the extension header
    if (has_ext && p >= HDR_BYTES && (p == base + 2 || p == base + 3))
      ext_len_acc = {ext_len_acc[7:0], d};

    if (pkt_count != '1) pkt_count = pkt_count + 1'b1;

    if (last) begin
      len = {{(32-COUNT_BITS){1'b0}}, pkt_count};
      want = '0;
      want.kind = KIND_VERDICT;
      if (len < HDR_BYTES) begin
        want.verdict.status = ST_SHORT;
      end else begin
        want.verdict.padding_flag    = hdr_byte0[5];
        want.verdict.extension_flag  = hdr_byte0[4];
        want.verdict.contrib_count   = hdr_byte0[3:0];
        want.verdict.marker_flag     = hdr_byte1[7];
        want.verdict.media_type      = hdr_byte1[6:0];
        want.verdict.sequence_number = seq_acc;
        want.verdict.media_stamp     = ts_acc;
        want.verdict.source_id       = ssrc_acc;
        // Check order matters: the first failing check names the status
        if (!ver_ok) begin
          want.verdict.status = ST_BAD_VERSION;
        end else if (base > len) begin
          want.verdict.status = ST_CSRC_BEYOND;
        end else if (has_ext && base + 4 > len) begin
          want.verdict.status = ST_EXT_BEYOND;
        end else begin
          hl = has_ext ? base + 4 + {14'd0, ext_len_acc, 2'b00} : base;
          want.verdict.status = (hl > len) ? ST_HDR_BEYOND : ST_OK;
          want.verdict.header_length = hl[HL_BITS-1:0];
        end
      end
      expected_rtp_beats.push_back(want);
      // Clear everything for the next packet
      pkt_count = '0;
      hdr_byte0 = '0;
      hdr_byte1 = '0;
      seq_acc = '0;
      ts_acc = '0;
      ssrc_acc = '0;
      csrc_acc = '0;
      ext_len_acc = '0;
    end
  endtask

  // Offer one byte, hold it until the parser takes it, then predict.
  // Called at a rising edge; push changes at most once per edge.
  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) begin
      full_stall_cycles++;
      @(posedge clk);
    end
    predict_rtp_beats(d, last);
    bytes_sent++;
    if (last) packets_sent++;
  endtask

  function automatic logic [7:0] fill_byte(input int mode);
    if (mode == FILL_ZEROS) return 8'h00;
    if (mode == FILL_ONES) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Lay out a packet in pkt_bytes: fixed header, CSRC list, optional
  // extension header with ext_words of contents, then the payload.
  task automatic build_packet(input logic [1:0] ver, input logic ext, input logic [3:0] cc,
                              input logic [15:0] ext_len, input int ext_words,
                              input int payload, input int mode);
    logic pad;
    pad = (mode == FILL_RANDOM) ? 1'($urandom_range(0, 1)) : (mode == FILL_ONES);
    pkt_bytes.delete();
    pkt_bytes.push_back({ver, pad, ext, cc});
    repeat (HDR_BYTES - 1 + 4 * cc) pkt_bytes.push_back(fill_byte(mode));
    if (ext) begin
      repeat (2) pkt_bytes.push_back(fill_byte(mode));
      pkt_bytes.push_back(ext_len[15:8]);
      pkt_bytes.push_back(ext_len[7:0]);
      repeat (4 * ext_words) pkt_bytes.push_back(fill_byte(mode));
    end
    repeat (payload) pkt_bytes.push_back(fill_byte(mode));
  endtask

  // Send the first n bytes of pkt_bytes, flagging the n-th as last
  task automatic send_packet(input int n);
    for (int i = 0; i < n; i++) send_byte(pkt_bytes[i], i == n - 1);
  endtask

  task automatic note_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare one popped beat against the oldest expectation
  task automatic check_result_beat();
    beat_t want;
    if (expected_rtp_beats.size() == 0) begin
      if (mismatch_count < 10)
        $display("%0t: unexpected beat, kind %0d status %0d", $time, out_kind, out_status);
      mismatch_count++;
      return;
    end
    want = expected_rtp_beats.pop_front();
    if (out_kind == KIND_CSRC) csrc_beats_seen++;
    else verdicts_seen++;
    note_field("kind", 32'(want.kind), 32'(out_kind));
    note_field("status", 32'(want.verdict.status), 32'(out_status));
    note_field("padding_flag", 32'(want.verdict.padding_flag), 32'(out_padding_flag));
    note_field("extension_flag", 32'(want.verdict.extension_flag),
               32'(out_extension_flag));
    note_field("contrib_count", 32'(want.verdict.contrib_count), 32'(out_contrib_count));
    note_field("marker_flag", 32'(want.verdict.marker_flag), 32'(out_marker_flag));
    note_field("media_type", 32'(want.verdict.media_type), 32'(out_media_type));
    note_field("sequence_number", 32'(want.verdict.sequence_number),
               32'(out_sequence_number));
    note_field("media_stamp", want.verdict.media_stamp, out_media_stamp);
    note_field("source_id", want.verdict.source_id, out_source_id);
    note_field("header_length", 32'(want.verdict.header_length), 32'(out_header_length));
    note_field("csrc_value", want.csrc_value, out_csrc_value);
  endtask

  // Result side: check each accepted beat, then decide the next pop.
  // rx_held (owned by the back-pressure test) overrides random stalls.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_result_beat();
    if (rx_held) begin
      out_pop <= 1'b0;
    end else if (pop_wait > 0) begin
      out_pop  <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      out_pop  <= 1'b1;
      pop_wait <= rx_idle ? pick_gap() : 0;
    end
  end

  // Hand-picked packets: field extremes and every verdict status
  task automatic test_directed();
    // One byte of all ones: short packet whose only byte is byte 0
    build_packet(2'd3, 1'b1, 4'd15, 16'hFFFF, 0, 0, FILL_ONES);
    send_packet(1);
    // One byte under a full fixed header
    build_packet(2'd0, 1'b0, 4'd0, 16'h0000, 0, 0, FILL_ZEROS);
    send_packet(HDR_BYTES - 1);
    // Version 0 and 1 with a complete fixed header
    send_packet(HDR_BYTES);
    build_packet(2'd1, 1'b0, 4'd0, 16'h0000, 0, 0, FILL_RANDOM);
    send_packet(HDR_BYTES);
    // Version 3 with CSRC bytes present: no CSRC words come out
    build_packet(2'd3, 1'b0, 4'd2, 16'h0000, 0, 0, FILL_ONES);
    send_packet(pkt_bytes.size());
    // CSRC list cut after two of three words
    build_packet(RTP_VERSION, 1'b0, 4'd3, 16'h0000, 0, 0, FILL_ONES);
    send_packet(HDR_BYTES + 8);
    // Extension header cut in the middle
    build_packet(RTP_VERSION, 1'b1, 4'd0, 16'h0001, 0, 0, FILL_RANDOM);
    send_packet(HDR_BYTES + 2);
    // Largest extension length with only four payload bytes behind it
    build_packet(RTP_VERSION, 1'b1, 4'd1, 16'hFFFF, 0, 4, FILL_RANDOM);
    send_packet(pkt_bytes.size());
    // Full CSRC list and extension ending exactly at the last byte
    build_packet(RTP_VERSION, 1'b1, 4'd15, 16'h0002, 2, 0, FILL_ONES);
    send_packet(pkt_bytes.size());
    // Minimal well-formed packet of all zero fields
    build_packet(RTP_VERSION, 1'b0, 4'd0, 16'h0000, 0, 0, FILL_ZEROS);
    send_packet(pkt_bytes.size());
  endtask

  // Random packets, mostly well formed, with idling switched on and off
  task automatic test_random_packets();
    int start_bytes;
    int r;
    int words;
    logic [3:0] cc;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle <= $urandom_range(0, 3) != 0;
      cc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
      words = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Well formed; now and then an extension length that overruns
        if ($urandom_range(0, 7) == 0)
          build_packet(RTP_VERSION, 1'b1, cc, 16'($urandom_range(0, 65535)), words,
                       $urandom_range(0, 6), FILL_RANDOM);
        else
          build_packet(RTP_VERSION, 1'($urandom_range(0, 1)), cc, 16'(words), words,
                       $urandom_range(0, 6), FILL_RANDOM);
        send_packet(pkt_bytes.size());
      end else if (r < 85) begin
        // Well formed but cut at a random point
        build_packet(RTP_VERSION, 1'($urandom_range(0, 1)), cc, 16'(words), words,
                     $urandom_range(0, 4), FILL_RANDOM);
        send_packet($urandom_range(1, pkt_bytes.size()));
      end else if (r < 95) begin
        // Line noise
        pkt_bytes.delete();
        repeat ($urandom_range(1, 16)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        send_packet(pkt_bytes.size());
      end else begin
        build_packet($urandom_range(0, 1) ? 2'd3 : 2'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), cc, 16'(words), words, 2, FILL_RANDOM);
        send_packet(pkt_bytes.size());
      end
    end
  endtask

  // Hold pop low for a long stretch while one-byte packets keep coming,
  // so the event queue fills and full holds the sender off
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    fork
      begin
        rx_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_held <= 1'b0;
      end
    join_none
    repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b1);
    build_packet(RTP_VERSION, 1'b0, 4'd15, 16'h0000, 0, 0, FILL_RANDOM);
    send_packet(pkt_bytes.size());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_packets();
    test_backpressure();
    in_push <= 1'b0;
    // Drain: wait out every expected beat, then watch for strays
    while (expected_rtp_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d packets in %0d bytes; checked %0d CSRC words and %0d verdicts.",
             packets_sent, bytes_sent, csrc_beats_seen, verdicts_seen);
    $display("Input held off by full for %0d cycles; %0d field mismatches.",
             full_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && expected_rtp_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
